>>> hw/rtl/mmd_pkg.sv
`timescale 1ns / 1ps

package mmd_pkg;

  localparam int unsigned ADDR_W         = 16;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned TGT_W          = 4;

  localparam int unsigned WORK_RAM_BYTES = 8192;
  localparam int unsigned HIGH_RAM_BYTES = 127;
  localparam int unsigned WRAM_DEPTH     = WORK_RAM_BYTES;
  localparam int unsigned WRAM_AW        = $clog2(WRAM_DEPTH);
  // High RAM is rounded up to a power of two; only the clear sweep addresses the top entry.
  localparam int unsigned HRAM_AW        = $clog2(HIGH_RAM_BYTES + 1);
  localparam int unsigned HRAM_DEPTH     = 1 << HRAM_AW;

  // Bits of the mode field.
  localparam int unsigned MODE_WRITE_BIT = 0;
  localparam int unsigned MODE_WORD_BIT  = 1;

  // APB register map.
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam logic        REG_IDX_OVERLAY = 1'b0;

  typedef enum logic [TGT_W-1:0] {
    TGT_BOOT = 4'd0,
    TGT_CART = 4'd1,
    TGT_VRAM = 4'd2,
    TGT_OAM  = 4'd3,
    TGT_IO   = 4'd4,
    TGT_WRAM = 4'd5,
    TGT_HRAM = 4'd6,
    TGT_IE   = 4'd7,
    TGT_NONE = 4'd8
  } target_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESULT,
    ST_HIGH
  } state_e;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic               clr;
    logic [WRAM_AW-1:0] clr_addr;
    logic               issue;
    logic               use_in;
    logic               load;
    logic               last;
  } ctl_t;

  typedef struct packed {
    target_e           tgt;
    logic [ADDR_W-1:0] off;
  } dec_t;

endpackage

>>> hw/rtl/mmd_req_if.sv
`timescale 1ns / 1ps

interface mmd_req_if;
  import mmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output mode, output address, output write_data, input ready);
  modport sink   (input valid, input mode, input address, input write_data, output ready);
endinterface

>>> hw/rtl/mmd_rsp_if.sv
`timescale 1ns / 1ps

interface mmd_rsp_if;
  import mmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [TGT_W-1:0]    target;
  logic                is_write;
  logic [ADDR_W-1:0]   offset;
  logic [BYTE_W-1:0]   byte_data;
  logic                last;

  modport source (output valid, output target, output is_write, output offset,
                  output byte_data, output last, input ready);
  modport sink   (input valid, input target, input is_write, input offset,
                  input byte_data, input last, output ready);
endinterface

>>> hw/rtl/mmd_ram.sv
`timescale 1ns / 1ps

module mmd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mmd_ctrl.sv
`timescale 1ns / 1ps

module mmd_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         req_word_i,
  input  logic         out_free_i,
  output logic         req_ready_o,
  output mmd_pkg::ctl_t ctl_o
);
  import mmd_pkg::*;

  state_e              state_q, state_d;
  logic [WRAM_AW-1:0]  cnt_q, cnt_d;
  logic                word_q, word_d;
  logic                hi_q, hi_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      word_q  <= 1'b0;
      hi_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      word_q  <= word_d;
      hi_q    <= hi_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    hi_d    = hi_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          word_d  = req_word_i;
          hi_d    = 1'b0;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free_i) begin
          if (word_q && !hi_q) begin
            hi_d    = 1'b1;
            state_d = ST_HIGH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_HIGH: begin
        state_d = ST_RESULT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o    = 1'b0;
    ctl_o          = '0;
    ctl_o.clr_addr = cnt_q;
    ctl_o.last     = !word_q || hi_q;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clr = 1'b1;
      end
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        ctl_o.issue  = req_valid_i;
        ctl_o.use_in = 1'b1;
      end
      ST_RESULT: begin
        ctl_o.load = out_free_i;
      end
      ST_HIGH: begin
        ctl_o.issue = 1'b1;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/mmd_datapath.sv
`timescale 1ns / 1ps

module mmd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmd_pkg::ctl_t               ctl_i,
  input  logic                        overlay_i,
  input  logic [mmd_pkg::MODE_W-1:0]  req_mode_i,
  input  logic [mmd_pkg::ADDR_W-1:0]  req_address_i,
  input  logic [mmd_pkg::DATA_W-1:0]  req_write_data_i,
  output logic                        out_free_o,
  mmd_rsp_if.source                   rsp
);
  import mmd_pkg::*;

  function automatic dec_t decode(input logic [ADDR_W-1:0] a, input logic wr,
                                  input logic ov);
    dec_t d;
    d.tgt = TGT_NONE;
    d.off = a;
    if (a inside {[16'h0000:16'h7FFF]}) begin
      if (wr) begin
        d.tgt = (ov && a <= 16'h0100) ? TGT_NONE : TGT_CART;
      end else begin
        d.tgt = (ov && a <= 16'h00FF) ? TGT_BOOT : TGT_CART;
      end
    end else if (a inside {[16'h8000:16'h9FFF]}) begin
      d.tgt = TGT_VRAM;
      d.off = {3'b000, a[12:0]};
    end else if (a inside {[16'hA000:16'hBFFF]}) begin
      d.tgt = TGT_CART;
    end else if (a inside {[16'hC000:16'hFDFF]}) begin
      // Work RAM and its echo both map to the low 13 address bits.
      d.tgt = TGT_WRAM;
      d.off = {3'b000, a[12:0]};
    end else if (a inside {[16'hFE00:16'hFE9F]}) begin
      d.tgt = TGT_OAM;
      d.off = {8'h00, a[7:0]};
    end else if (a inside {[16'hFEA0:16'hFEFF]}) begin
      d.tgt = TGT_NONE;
    end else if (a inside {[16'hFF00:16'hFF7F]}) begin
      d.tgt = TGT_IO;
      d.off = {8'h00, a[7:0]};
    end else if (a inside {[16'hFF80:16'hFFFE]}) begin
      d.tgt = TGT_HRAM;
      d.off = {9'h000, a[6:0]};
    end else begin
      d.tgt = TGT_IE;
      d.off = '0;
    end
    return d;
  endfunction

  // Held copy of the accepted item for the high byte of a word access.
  logic [ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0] hi_data_q;
  logic              wr_q;

  // Issue stage selection.
  logic [ADDR_W-1:0] addr_b;
  logic [BYTE_W-1:0] data_b;
  logic              wr_b;
  dec_t              dec;

  // Byte in flight between issue and result.
  target_e           tgt_q;
  logic [ADDR_W-1:0] off_q;
  logic              bwr_q;
  logic [BYTE_W-1:0] bdata_q;

  logic [BYTE_W-1:0] ie_q;

  logic              wram_we, wram_re, hram_we, hram_re;
  logic [WRAM_AW-1:0] wram_addr;
  logic [HRAM_AW-1:0] hram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] wram_rdata, hram_rdata;

  logic [BYTE_W-1:0] val;

  logic              out_valid_q, out_valid_d;
  target_e           out_tgt_q;
  logic              out_wr_q;
  logic [ADDR_W-1:0] out_off_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;

  assign addr_b = ctl_i.use_in ? req_address_i : addr_q + 1'b1;
  assign data_b = ctl_i.use_in ? req_write_data_i[BYTE_W-1:0] : hi_data_q;
  assign wr_b   = ctl_i.use_in ? req_mode_i[MODE_WRITE_BIT] : wr_q;
  assign dec    = decode(addr_b, wr_b, overlay_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue && ctl_i.use_in) begin
      addr_q    <= req_address_i;
      hi_data_q <= req_write_data_i[DATA_W-1:BYTE_W];
      wr_q      <= req_mode_i[MODE_WRITE_BIT];
    end
    if (ctl_i.issue) begin
      tgt_q   <= dec.tgt;
      off_q   <= dec.off;
      bwr_q   <= wr_b;
      bdata_q <= data_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ie_q <= '0;
    end else if (ctl_i.issue && wr_b && dec.tgt == TGT_IE) begin
      ie_q <= data_b;
    end
  end

  assign ram_wdata = ctl_i.clr ? '0 : data_b;
  assign wram_we   = ctl_i.clr || (ctl_i.issue && wr_b && dec.tgt == TGT_WRAM);
  assign wram_re   = ctl_i.issue && !wr_b && dec.tgt == TGT_WRAM;
  assign wram_addr = ctl_i.clr ? ctl_i.clr_addr : dec.off[WRAM_AW-1:0];
  assign hram_we   = ctl_i.clr || (ctl_i.issue && wr_b && dec.tgt == TGT_HRAM);
  assign hram_re   = ctl_i.issue && !wr_b && dec.tgt == TGT_HRAM;
  assign hram_addr = ctl_i.clr ? ctl_i.clr_addr[HRAM_AW-1:0] : dec.off[HRAM_AW-1:0];

  mmd_ram #(
    .Width(BYTE_W),
    .Depth(WRAM_DEPTH)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (wram_we),
    .re_i   (wram_re),
    .addr_i (wram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(wram_rdata)
  );

  mmd_ram #(
    .Width(BYTE_W),
    .Depth(HRAM_DEPTH)
  ) u_hram (
    .clk_i  (clk_i),
    .we_i   (hram_we),
    .re_i   (hram_re),
    .addr_i (hram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(hram_rdata)
  );

  always_comb begin
    if (bwr_q) begin
      val = bdata_q;
    end else begin
      case (tgt_q)
        TGT_WRAM: val = wram_rdata;
        TGT_HRAM: val = hram_rdata;
        TGT_IE:   val = ie_q;
        TGT_NONE: val = 8'hFF;
        default:  val = '0;
      endcase
    end
  end

  assign out_free_o  = !out_valid_q || rsp.ready;
  assign out_valid_d = ctl_i.load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      out_tgt_q  <= tgt_q;
      out_wr_q   <= bwr_q;
      out_off_q  <= off_q;
      out_data_q <= val;
      out_last_q <= ctl_i.last;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.target    = out_tgt_q;
  assign rsp.is_write  = out_wr_q;
  assign rsp.offset    = out_off_q;
  assign rsp.byte_data = out_data_q;
  assign rsp.last      = out_last_q;

endmodule

>>> hw/rtl/memory_map_decoder_with_local_ram.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer carries
// req_i     in         mode, address, write_data (one CPU access)
// rsp_o     out        target, is_write, offset, byte_data, last (one byte access)
// APB       in         boot_overlay_on at byte address 0
//
// A byte access is decoded and its work RAM or high RAM access issued in
// the idle state; the result state loads the registered read data into the
// output register; a word's high byte is issued in the high state. After reset
// both RAMs are swept to zero and no request taken; APB writes go on throughout.
// A stalled result sits in the output register; the next request is still
// accepted, and only loading of a new result waits for that register to empty.

module memory_map_decoder_with_local_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mmd_req_if.sink                      req_i,
  mmd_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [mmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [mmd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mmd_pkg::*;

  ctl_t ctl;
  logic out_free;
  logic req_ready;
  logic overlay_q;

  // The register index is the word address; only index zero is implemented,
  // and a write elsewhere has no effect.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlay_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDX_OVERLAY) begin
      overlay_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_OVERLAY) ? {{(PDATA_W-1){1'b0}}, overlay_q} : '0;

  // The sequencer owns the handshake on the request side and steps through
  // the low and the high byte of a word access.
  mmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_word_i (req_i.mode[MODE_WORD_BIT]),
    .out_free_i (out_free),
    .req_ready_o(req_ready),
    .ctl_o      (ctl)
  );

  assign req_i.ready = req_ready;

  // Address decode, the two RAMs, the interrupt-enable byte and the output
  // register that holds each byte result until it is transferred.
  mmd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .overlay_i       (overlay_q),
    .req_mode_i      (req_i.mode),
    .req_address_i   (req_i.address),
    .req_write_data_i(req_i.write_data),
    .out_free_o      (out_free),
    .rsp             (rsp_o)
  );

endmodule
